[sv/hc3_pkg.sv]
package hc3_pkg;

  localparam int unsigned SymW          = 5;
  localparam int unsigned KeyW          = 45;
  localparam int unsigned RowW          = 15;
  localparam int unsigned ProdW         = 10;
  localparam int unsigned SumW          = 12;
  localparam int unsigned QuotW         = 8;
  localparam int unsigned HillMod       = 26;
  localparam int unsigned GroupDepthDef = 2;
  localparam int unsigned OutDepthDef   = 8;

  // floor(2^16 / 26); underestimates the quotient by at most one over the sum range
  localparam logic [SumW-1:0] RecipMul = 12'd2520;

  typedef logic [SymW-1:0] sym_t;

  localparam sym_t PadSymbol = 5'd23;

  typedef struct packed {
    sym_t s0;
    sym_t s1;
    sym_t s2;
    logic last;
  } group_t;

  typedef struct packed {
    sym_t sym;
    logic last;
  } cipher_t;

  typedef enum logic [1:0] {
    ROW0,
    ROW1,
    ROW2
  } row_t;

endpackage

[sv/hill_cipher_3x3_encrypt.sv]
// 3x3 hill cipher encryptor, modulo 26. plaintext symbols (0..25) come in
// through a queue-style push/full port, one per cycle; message_end marks the
// last symbol of a message. symbols are gathered in threes and each group
// leaves as three cipher symbols, row j of the key dotted with the group and
// reduced mod 26. a message that ends mid-group is padded with 'X' (23); a
// message whose length is a multiple of three gets no padding. last_out is
// set on the third cipher symbol of the closing group. results are read
// through empty/pop. the key (nine 5-bit entries, row-major, entry r*3+c at
// bits 5*(r*3+c)) is written on the cfg channel, always ready; the user must
// write it only while the block is idle, which the block does not enforce.
// sustained rate is one symbol per cycle in and out while the receiver
// keeps popping: the single row unit produces one cipher symbol per cycle;
// a message end on a short group yields three results for one or two
// symbols and the input side then waits on that unit.
// no clearing pass after reset.
module hill_cipher_3x3_encrypt #(
  parameter int GROUP_DEPTH = hc3_pkg::GroupDepthDef,
  parameter int OUT_DEPTH   = hc3_pkg::OutDepthDef
) (
  input  logic                      clk,
  input  logic                      rst,
  // plaintext request side
  input  logic                      push,
  output logic                      full,
  input  logic [hc3_pkg::SymW-1:0]  plain_symbol,
  input  logic                      message_end,
  // ciphertext side
  output logic                      empty,
  input  logic                      pop,
  output logic [hc3_pkg::SymW-1:0]  cipher_symbol,
  output logic                      last_out,
  // key write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [hc3_pkg::KeyW-1:0]  key_matrix
);

  import hc3_pkg::*;

  logic [KeyW-1:0] key;

  group_t  grp_in;
  group_t  grp_head;
  logic    grp_push;
  logic    grp_full;
  logic    grp_pop;
  logic    grp_empty;

  cipher_t cip_in;
  cipher_t cip_head;
  logic    cip_push;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_level;

  // key register, taken on every valid request
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_valid && cfg_ready) begin
      key <= key_matrix;
    end
  end

  // front: gathers symbols and closes groups, padding short ones
  hc3_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .plain_symbol (plain_symbol),
    .message_end  (message_end),
    .grp          (grp_in),
    .grp_push     (grp_push),
    .grp_full     (grp_full)
  );

  // short group queue decoupling front and back
  hc3_fifo #(
    .WIDTH ($bits(group_t)),
    .DEPTH (GROUP_DEPTH)
  ) u_group_q (
    .clk   (clk),
    .rst   (rst),
    .push  (grp_push),
    .din   (grp_in),
    .full  (grp_full),
    .pop   (grp_pop),
    .dout  (grp_head),
    .empty (grp_empty),
    .count ()
  );

  // back: one key row per cycle unless stalled; multiply, sum, mod 26 stages
  hc3_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .key       (key),
    .grp       (grp_head),
    .grp_empty (grp_empty),
    .grp_pop   (grp_pop),
    .out_level (out_level),
    .cip       (cip_in),
    .cip_push  (cip_push)
  );

  // result queue; the back issues only when a slot is reserved for it
  hc3_fifo #(
    .WIDTH ($bits(cipher_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cip_push),
    .din   (cip_in),
    .full  (),
    .pop   (pop),
    .dout  (cip_head),
    .empty (empty),
    .count (out_level)
  );

  assign cipher_symbol = cip_head.sym;
  assign last_out      = cip_head.last;

endmodule

[sv/hc3_fifo.sv]
module hc3_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [WIDTH-1:0]             din,
  output logic                         full,
  input  logic                         pop,
  output logic [WIDTH-1:0]             dout,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[sv/hc3_front.sv]
module hc3_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  hc3_pkg::sym_t  plain_symbol,
  input  logic           message_end,
  output hc3_pkg::group_t grp,
  output logic           grp_push,
  input  logic           grp_full
);

  import hc3_pkg::*;

  sym_t       held0;
  sym_t       held1;
  logic [1:0] count;
  logic       accept;

  assign full     = grp_full;
  assign accept   = push && !grp_full;
  // a group closes on its third symbol or on the message end
  assign grp_push = accept && (count == 2'd2 || message_end);

  always_comb begin
    grp.last = message_end;
    case (count)
      2'd0: begin
        grp.s0 = plain_symbol;
        grp.s1 = PadSymbol;
        grp.s2 = PadSymbol;
      end
      2'd1: begin
        grp.s0 = held0;
        grp.s1 = plain_symbol;
        grp.s2 = PadSymbol;
      end
      default: begin
        grp.s0 = held0;
        grp.s1 = held1;
        grp.s2 = plain_symbol;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= grp_push ? 2'd0 : count + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !grp_push) begin
      if (count[0]) begin
        held1 <= plain_symbol;
      end else begin
        held0 <= plain_symbol;
      end
    end
  end

endmodule

[sv/hc3_back.sv]
module hc3_back #(
  parameter int OUT_DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [hc3_pkg::KeyW-1:0]          key,
  input  hc3_pkg::group_t                   grp,
  input  logic                              grp_empty,
  output logic                              grp_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]    out_level,
  output hc3_pkg::cipher_t                  cip,
  output logic                              cip_push
);

  import hc3_pkg::*;

  localparam int LW = $clog2(OUT_DEPTH+1);

  row_t              row;
  row_t              row_next;
  logic              issue;
  logic [LW:0]       used;
  logic [RowW-1:0]   krow;
  sym_t              k0, k1, k2;

  logic              v1, v2, v3;
  logic [ProdW-1:0]  p0, p1, p2;
  logic              last1, last2, last3;
  logic [SumW-1:0]   sum2, sum3;
  logic [QuotW-1:0]  q3;
  logic [2*SumW-1:0] prod;
  logic [SumW-1:0]   rem;
  logic [SumW-1:0]   rem_fix;

  // results in flight plus those queued must fit the output queue
  assign used  = {1'b0, out_level} + (LW+1)'(v1) + (LW+1)'(v2) + (LW+1)'(v3);
  assign issue = !grp_empty && (used < (LW+1)'(OUT_DEPTH));
  assign grp_pop = issue && (row == ROW2);

  always_comb begin
    row_next = row;
    krow     = key[RowW-1:0];
    case (row)
      ROW0: begin
        krow = key[RowW-1:0];
        if (issue) row_next = ROW1;
      end
      ROW1: begin
        krow = key[2*RowW-1:RowW];
        if (issue) row_next = ROW2;
      end
      ROW2: begin
        krow = key[3*RowW-1:2*RowW];
        if (issue) row_next = ROW0;
      end
      default: begin
        row_next = ROW0;
      end
    endcase
  end

  assign k0 = krow[SymW-1:0];
  assign k1 = krow[2*SymW-1:SymW];
  assign k2 = krow[3*SymW-1:2*SymW];

  // mod 26 by reciprocal: q from the product, then one compare and subtract
  assign prod    = (2*SumW)'(sum2) * (2*SumW)'(RecipMul);
  assign rem     = sum3 - SumW'(q3) * SumW'(HillMod);
  assign rem_fix = (rem >= SumW'(HillMod)) ? rem - SumW'(HillMod) : rem;

  assign cip.sym  = rem_fix[SymW-1:0];
  assign cip.last = last3;
  assign cip_push = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= ROW0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
    end else begin
      row <= row_next;
      v1  <= issue;
      v2  <= v1;
      v3  <= v2;
    end
  end

  always_ff @(posedge clk) begin
    p0    <= ProdW'(k0) * ProdW'(grp.s0);
    p1    <= ProdW'(k1) * ProdW'(grp.s1);
    p2    <= ProdW'(k2) * ProdW'(grp.s2);
    last1 <= grp.last && (row == ROW2);
    sum2  <= SumW'(p0) + SumW'(p1) + SumW'(p2);
    last2 <= last1;
    q3    <= prod[2*SumW-1:16];
    sum3  <= sum2;
    last3 <= last2;
  end

endmodule

[bench/hill_cipher_3x3_encrypt_tb.sv]
`timescale 1ns / 1ps

module hill_cipher_3x3_encrypt_tb;
  import hc3_pkg::*;

  // run limits
  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 12;     // idle wait after the last owed result
  localparam int RxHoldCycles = 300;    // long receiver stall, enough to fill the block
  localparam logic [KeyW-1:0] KeyAllOnes = {KeyW{1'b1}};

  // clock and reset
  logic clk;
  logic rst = 1'b1;

  // plaintext request side
  logic            push         = 1'b0;
  logic            full;
  sym_t            plain_symbol = '0;
  logic            message_end  = 1'b0;

  // ciphertext side
  logic            empty;
  logic            pop          = 1'b0;
  sym_t            cipher_symbol;
  logic            last_out;

  // key write channel
  logic            cfg_valid    = 1'b0;
  logic            cfg_ready;
  logic [KeyW-1:0] key_matrix   = '0;

  hill_cipher_3x3_encrypt dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .plain_symbol (plain_symbol),
    .message_end  (message_end),
    .empty        (empty),
    .pop          (pop),
    .cipher_symbol(cipher_symbol),
    .last_out     (last_out),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .key_matrix   (key_matrix)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // predictor state: key copy, partial group, and cipher symbols still owed
  logic [KeyW-1:0] key_shadow = '0;
  sym_t            held_syms [2];
  int unsigned     held_count = 0;
  cipher_t         expected_ciphers [$];

  int errors       = 0;
  int cycle_count  = 0;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;

  // receiver hold-off: a toggle from the stimulus side starts a counted stall
  logic hold_req   = 1'b0;
  logic hold_seen  = 1'b0;
  int   hold_left  = 0;

  // one accepted plaintext symbol: gather, or close the group (padding with 'X')
  // and queue its three cipher symbols, row j of the key dotted with the group
  function automatic void encrypt_symbol(input sym_t plain, input logic end_flag);
    sym_t        grp [3];
    int unsigned dot;
    if (held_count < 2 && !end_flag) begin
      held_syms[held_count] = plain;
      held_count++;
      return;
    end
    grp[0] = (held_count == 0) ? plain : held_syms[0];
    grp[1] = (held_count == 0) ? PadSymbol : (held_count == 1) ? plain : held_syms[1];
    grp[2] = (held_count == 2) ? plain : PadSymbol;
    for (int r = 0; r < 3; r++) begin
      dot = 0;
      for (int c = 0; c < 3; c++)
        dot += int'(key_shadow[5*(r*3+c) +: 5]) * int'(grp[c]);
      expected_ciphers.push_back('{sym: sym_t'(dot % HillMod), last: end_flag && r == 2});
    end
    held_count = 0;
  endfunction

  // mostly real letters, now and then a raw 5-bit value past 'Z'
  function automatic sym_t random_symbol();
    return ($urandom_range(9) == 0) ? sym_t'($urandom_range(31, 26))
                                    : sym_t'($urandom_range(25));
  endfunction

  // key with in-range entries most of the time, otherwise any 45-bit value
  function automatic logic [KeyW-1:0] random_key();
    logic [KeyW-1:0] key;
    key = KeyW'({$urandom, $urandom});
    if ($urandom_range(3) != 0)
      for (int i = 0; i < 9; i++) key[5*i +: 5] = sym_t'($urandom_range(25));
    return key;
  endfunction

  // one plaintext request, with random idle cycles ahead of it
  task automatic send_symbol(input sym_t plain, input logic end_flag);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    plain_symbol <= plain;
    message_end  <= end_flag;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    encrypt_symbol(plain, end_flag);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_symbol(random_symbol(), i == len - 1);
  endtask

  // stop sending and wait for every owed cipher symbol, then let the block settle
  task automatic drain_ciphers();
    push <= 1'b0;
    do @(posedge clk); while (expected_ciphers.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // key write, only ever called with the block idle at a message boundary
  task automatic write_key(input logic [KeyW-1:0] key);
    cfg_valid  <= 1'b1;
    key_matrix <= key;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid  <= 1'b0;
    key_shadow = key;
  endtask

  // reset key is all zero, then a classic key and an all-ones key over short
  // messages: end on an empty group, end with one symbol held, whole groups
  task automatic test_directed_groups();
    send_symbol(5'd0, 1'b0);
    send_symbol(5'd25, 1'b0);
    send_symbol(5'd31, 1'b1);
    drain_ciphers();
    write_key({5'd15, 5'd17, 5'd20, 5'd10, 5'd16, 5'd13, 5'd1, 5'd24, 5'd6});
    send_symbol(5'd0, 1'b1);
    send_symbol(5'd25, 1'b0);
    send_symbol(5'd0, 1'b1);
    send_symbol(5'd0, 1'b0);
    send_symbol(5'd2, 1'b0);
    send_symbol(5'd19, 1'b1);
    send_symbol(5'd31, 1'b0);
    send_symbol(5'd26, 1'b0);
    send_symbol(5'd25, 1'b0);
    send_symbol(5'd0, 1'b1);
    drain_ciphers();
    write_key(KeyAllOnes);
    send_symbol(5'd25, 1'b0);
    send_symbol(5'd25, 1'b0);
    send_symbol(5'd25, 1'b1);
    send_symbol(5'd31, 1'b1);
    drain_ciphers();
  endtask

  // sweep of keys, both extremes among them
  task automatic test_key_sweep();
    for (int k = 0; k < 8; k++) begin
      case (k)
        0:       write_key('0);
        1:       write_key(KeyAllOnes);
        default: write_key(random_key());
      endcase
      send_message($urandom_range(7, 1));
      drain_ciphers();
    end
  endtask

  // well-formed messages of random length and content under one idling pattern
  task automatic test_random_messages(input int tx_pct, input int rx_pct, input int items);
    int sent;
    int len;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    write_key(random_key());
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(15) == 0) ? $urandom_range(40, 20) : $urandom_range(10, 1);
      send_message(len);
      sent += len;
      // now and then the sender waits for every owed result mid-phase
      if ($urandom_range(7) == 0) drain_ciphers();
    end
    drain_ciphers();
  endtask

  // receiver stalls for a long stretch while requests keep coming, so the
  // block fills and raises full; then the sender pauses until all is drained
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_key(random_key());
    hold_req <= ~hold_req;
    for (int m = 0; m < 14; m++) send_message(3);
    send_message(2);
    drain_ciphers();
    send_message(5);
    drain_ciphers();
  endtask

  // receiver: check the request taken at this edge, then pick the next pop
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && empty === 1'b0) begin
        if (expected_ciphers.size() == 0) begin
          $display("%0t: unexpected cipher request: actual symbol %0d last %0b",
                   $time, cipher_symbol, last_out);
          errors++;
        end else begin
          if (cipher_symbol !== expected_ciphers[0].sym) begin
            $display("%0t: cipher_symbol mismatch: expected %0d actual %0d",
                     $time, expected_ciphers[0].sym, cipher_symbol);
            errors++;
          end
          if (last_out !== expected_ciphers[0].last) begin
            $display("%0t: last_out mismatch: expected %0b actual %0b",
                     $time, expected_ciphers[0].last, last_out);
            errors++;
          end
          void'(expected_ciphers.pop_front());
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = RxHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed_groups();
    test_key_sweep();
    // sender light idling, receiver heavy; then reversed; then flat out
    test_random_messages(18, 78, 100);
    test_random_messages(78, 18, 100);
    test_random_messages(0, 0, 100);
    test_backpressure();
    drain_ciphers();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
